@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MRE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mre assertion failed");

// next-cycle implication
`define MRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mre assertion failed");

`endif

@@ src/mre_pkg.sv @@
package mre_pkg;

   localparam int RGB_BITS       = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FILL_ENABLE   = 2'd0,
      CSR_STROKE_ENABLE = 2'd1,
      CSR_FILL_RGB      = 2'd2,
      CSR_STROKE_RGB    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_IDLE = 2'd0,
      REGION_ONE  = 2'd1,
      REGION_TWO  = 2'd2
   } region_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ_RX,
      S_SQ_RY,
      S_SQ_DONE,
      S_BP_MUL,
      S_BP_INIT,
      S_R1_MOVE,
      S_R1_DEC,
      S_RC_TX,
      S_RC_XTERM,
      S_RC_TY,
      S_RC_YTERM,
      S_RC_CROSS,
      S_RC_DONE,
      S_R2_MOVE,
      S_R2_DEC,
      S_EMIT,
      S_FINISH
   } state_type;

endpackage

@@ src/mre_ifs.sv @@
interface mre_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [COORD_BITS-2:0] radius_x;
   logic [COORD_BITS-2:0] radius_y;

   modport source (output valid, func, center_x, center_y, radius_x, radius_y,
                   input ready);
   modport sink (input valid, func, center_x, center_y, radius_x, radius_y,
                 output ready);
endinterface

interface mre_rsp_if #(parameter int COORD_BITS = 12);
   import mre_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS+1:0] span_left;
   logic signed [COORD_BITS+1:0] span_right;
   logic signed [COORD_BITS+1:0] row;
   logic [RGB_BITS-1:0]          color;
   logic                         finished;
   logic                         last;

   modport source (output valid, span_left, span_right, row, color, finished, last,
                   input ready);
   modport sink (input valid, span_left, span_right, row, color, finished, last,
                 output ready);
endinterface

interface mre_csr_if;
   import mre_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/mre_mult.sv @@
module mre_mult #(
   parameter int WIDTH = 24
) (
   input  logic               clock,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic [2*WIDTH-1:0] product_ff
);

   logic [2*WIDTH-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ src/midpoint_ellipse_rasterizer.sv @@
// Start request: two squares and one pass setup product, then one cycle per item while
// the output slot is free. Step request: add/compare work, then one cycle per item while
// the output slot is free (2 spans or 4 points). Region change uses the shared multiplier;
// pass change reruns setup. One request in flight; the registered output lets the next
// request in while the last item still waits. Synchronous active-high reset: idle, no
// active pass, registers at their reset values (both passes on, fill white, stroke black).
module midpoint_ellipse_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input logic        clock,
   input logic        reset,
   mre_req_if.sink    req_bus,
   mre_rsp_if.source  rsp_bus,
   mre_csr_if.sink    csr_bus
);
   import mre_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int RB  = COORD_BITS - 1;
   localparam int SQB = 2 * RB;
   localparam int MW  = 2 * COORD_BITS;
   localparam int PW  = 2 * MW;
   localparam int DW  = 4 * COORD_BITS;
   localparam int SW  = 3 * COORD_BITS + 4;
   localparam int OW  = COORD_BITS + 2;

   state_type state_ff, state_in;
   region_type region_ff, region_in;
   logic stroke_pass_ff, stroke_pass_in;
   logic branch_ff, branch_in;
   logic [1:0] idx_ff, idx_in;

   logic fill_en_ff, fill_en_in;
   logic stroke_en_ff, stroke_en_in;
   logic [RGB_BITS-1:0] fill_rgb_ff, fill_rgb_in;
   logic [RGB_BITS-1:0] stroke_rgb_ff, stroke_rgb_in;

   logic [CB-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CB-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [RB-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SQB-1:0] rxsq_ff, rxsq_in, rysq_ff, rysq_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [DW-1:0] dec_ff, dec_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0] rsp_left_ff, rsp_left_in;
   logic signed [OW-1:0] rsp_right_ff, rsp_right_in;
   logic signed [OW-1:0] rsp_row_ff, rsp_row_in;
   logic [RGB_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic rsp_fin_ff, rsp_fin_in;
   logic rsp_last_ff, rsp_last_in;

   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] product;

   logic signed [DW-1:0] rxsq_w, rysq_w, sx_w, sy_w, prod_w, dec_sum;
   logic signed [SW-1:0] rxsq2_s, rysq2_s;
   logic signed [OW-1:0] col_pos, col_neg, row_lo, row_hi;
   logic [CB:0] tx;
   logic [CB-1:0] ty_abs;
   logic slot_free, item_last;

   mre_mult #(.WIDTH(MW)) u_mre_mult (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product)
   );

   assign rxsq_w  = signed'(DW'(rxsq_ff));
   assign rysq_w  = signed'(DW'(rysq_ff));
   assign sx_w    = DW'(sx_ff);
   assign sy_w    = DW'(sy_ff);
   assign prod_w  = signed'(DW'(product));
   assign rxsq2_s = signed'(SW'({rxsq_ff, 1'b0}));
   assign rysq2_s = signed'(SW'({rysq_ff, 1'b0}));

   assign tx     = {pos_x_ff, 1'b1};
   assign ty_abs = (pos_y_ff == '0) ? CB'(1) : pos_y_ff - CB'(1);

   assign col_pos = signed'(OW'(cx_ff)) + signed'(OW'(pos_x_ff));
   assign col_neg = signed'(OW'(cx_ff)) - signed'(OW'(pos_x_ff));
   assign row_lo  = signed'(OW'(cy_ff)) + signed'(OW'(pos_y_ff));
   assign row_hi  = signed'(OW'(cy_ff)) - signed'(OW'(pos_y_ff));

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign item_last = stroke_pass_ff ? (idx_ff == 2'd3) : (idx_ff == 2'd1);

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign csr_bus.ready      = 1'b1;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.span_left  = rsp_left_ff;
   assign rsp_bus.span_right = rsp_right_ff;
   assign rsp_bus.row        = rsp_row_ff;
   assign rsp_bus.color      = rsp_color_ff;
   assign rsp_bus.finished   = rsp_fin_ff;
   assign rsp_bus.last       = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff      <= REGION_IDLE;
         stroke_pass_ff <= 1'b0;
         idx_ff         <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         fill_en_ff     <= 1'b1;
         stroke_en_ff   <= 1'b1;
         fill_rgb_ff    <= {RGB_BITS{1'b1}};
         stroke_rgb_ff  <= '0;
      end else begin
         region_ff      <= region_in;
         stroke_pass_ff <= stroke_pass_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         fill_en_ff     <= fill_en_in;
         stroke_en_ff   <= stroke_en_in;
         fill_rgb_ff    <= fill_rgb_in;
         stroke_rgb_ff  <= stroke_rgb_in;
      end
   end

   always_ff @(posedge clock) begin
      branch_ff    <= branch_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rxsq_ff      <= rxsq_in;
      rysq_ff      <= rysq_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      dec_ff       <= dec_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_color_ff <= rsp_color_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in       = state_ff;
      region_in      = region_ff;
      stroke_pass_in = stroke_pass_ff;
      branch_in      = branch_ff;
      idx_in         = idx_ff;
      fill_en_in     = fill_en_ff;
      stroke_en_in   = stroke_en_ff;
      fill_rgb_in    = fill_rgb_ff;
      stroke_rgb_in  = stroke_rgb_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      rxsq_in        = rxsq_ff;
      rysq_in        = rysq_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      dec_in         = dec_ff;
      dec_sum        = '0;
      mul_a          = '0;
      mul_b          = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_left_in    = rsp_left_ff;
      rsp_right_in   = rsp_right_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_fin_in     = rsp_fin_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_FILL_ENABLE:   fill_en_in    = csr_bus.data[0];
            CSR_STROKE_ENABLE: stroke_en_in  = csr_bus.data[0];
            CSR_FILL_RGB:      fill_rgb_in   = csr_bus.data;
            CSR_STROKE_RGB:    stroke_rgb_in = csr_bus.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.func == FUNC_START) begin
                  cx_in    = req_bus.center_x;
                  cy_in    = req_bus.center_y;
                  rx_in    = req_bus.radius_x;
                  ry_in    = req_bus.radius_y;
                  state_in = S_SQ_RX;
               end else begin
                  case (region_ff)
                     REGION_ONE: state_in = (sx_ff < sy_ff) ? S_R1_MOVE : S_RC_TX;
                     REGION_TWO: state_in = S_R2_MOVE;
                     default:    state_in = S_FINISH;
                  endcase
               end
            end
         end
         S_SQ_RX: begin
            mul_a    = MW'(rx_ff);
            mul_b    = MW'(rx_ff);
            state_in = S_SQ_RY;
         end
         S_SQ_RY: begin
            rxsq_in  = product[SQB-1:0];
            mul_a    = MW'(ry_ff);
            mul_b    = MW'(ry_ff);
            state_in = S_SQ_DONE;
         end
         S_SQ_DONE: begin
            rysq_in = product[SQB-1:0];
            if (fill_en_ff) begin
               stroke_pass_in = 1'b0;
               state_in       = S_BP_MUL;
            end else if (stroke_en_ff) begin
               stroke_pass_in = 1'b1;
               state_in       = S_BP_MUL;
            end else begin
               region_in      = REGION_IDLE;
               stroke_pass_in = 1'b0;
               state_in       = S_FINISH;
            end
         end
         S_BP_MUL: begin
            mul_a     = MW'(rxsq_ff);
            mul_b     = MW'(ry_ff);
            pos_x_in  = '0;
            pos_y_in  = CB'(ry_ff);
            sx_in     = '0;
            region_in = REGION_ONE;
            state_in  = S_BP_INIT;
         end
         S_BP_INIT: begin
            // step_y = 2*rx^2*ry, decision = 4*ry^2 - 4*rx^2*ry + rx^2
            sy_in    = signed'(SW'({product, 1'b0}));
            dec_in   = (rysq_w <<< 2) + rxsq_w - (prod_w <<< 2);
            idx_in   = 2'd0;
            state_in = S_EMIT;
         end
         S_R1_MOVE: begin
            pos_x_in = pos_x_ff + CB'(1);
            sx_in    = sx_ff + rysq2_s;
            if (dec_ff[DW-1]) begin
               branch_in = 1'b0;
            end else begin
               pos_y_in  = pos_y_ff - CB'(1);
               sy_in     = sy_ff - rxsq2_s;
               branch_in = 1'b1;
            end
            state_in = S_R1_DEC;
         end
         S_R1_DEC: begin
            dec_sum  = rysq_w + sx_w - (branch_ff ? sy_w : '0);
            dec_in   = dec_ff + (dec_sum <<< 2);
            idx_in   = 2'd0;
            state_in = S_EMIT;
         end
         // region change: d = ry^2*tx^2 + 4*rx^2*ty^2 - 4*rx^2*ry^2
         S_RC_TX: begin
            mul_a    = MW'(tx);
            mul_b    = MW'(tx);
            state_in = S_RC_XTERM;
         end
         S_RC_XTERM: begin
            mul_a    = MW'(rysq_ff);
            mul_b    = product[MW-1:0];
            state_in = S_RC_TY;
         end
         S_RC_TY: begin
            dec_in   = prod_w;
            mul_a    = MW'(ty_abs);
            mul_b    = MW'(ty_abs);
            state_in = S_RC_YTERM;
         end
         S_RC_YTERM: begin
            mul_a    = MW'(rxsq_ff);
            mul_b    = product[MW-1:0];
            state_in = S_RC_CROSS;
         end
         S_RC_CROSS: begin
            dec_in   = dec_ff + (prod_w <<< 2);
            mul_a    = MW'(rxsq_ff);
            mul_b    = MW'(rysq_ff);
            state_in = S_RC_DONE;
         end
         S_RC_DONE: begin
            dec_in    = dec_ff - (prod_w <<< 2);
            region_in = REGION_TWO;
            state_in  = S_R2_MOVE;
         end
         S_R2_MOVE: begin
            if (pos_y_ff != '0) begin
               pos_y_in = pos_y_ff - CB'(1);
               sy_in    = sy_ff - rxsq2_s;
               if (!dec_ff[DW-1] && (dec_ff != '0)) begin
                  branch_in = 1'b0;
               end else begin
                  pos_x_in  = pos_x_ff + CB'(1);
                  sx_in     = sx_ff + rysq2_s;
                  branch_in = 1'b1;
               end
               state_in = S_R2_DEC;
            end else if (!stroke_pass_ff && stroke_en_ff) begin
               stroke_pass_in = 1'b1;
               state_in       = S_BP_MUL;
            end else begin
               region_in      = REGION_IDLE;
               stroke_pass_in = 1'b0;
               state_in       = S_FINISH;
            end
         end
         S_R2_DEC: begin
            dec_sum  = rxsq_w - sy_w + (branch_ff ? sx_w : '0);
            dec_in   = dec_ff + (dec_sum <<< 2);
            idx_in   = 2'd0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_fin_in   = 1'b0;
               rsp_last_in  = item_last;
               if (stroke_pass_ff) begin
                  // point order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
                  rsp_left_in  = idx_ff[0] ? col_neg : col_pos;
                  rsp_right_in = idx_ff[0] ? col_neg : col_pos;
                  rsp_row_in   = idx_ff[1] ? row_hi : row_lo;
                  rsp_color_in = stroke_rgb_ff;
               end else begin
                  rsp_left_in  = col_neg;
                  rsp_right_in = col_pos;
                  rsp_row_in   = idx_ff[0] ? row_hi : row_lo;
                  rsp_color_in = fill_rgb_ff;
               end
               if (item_last) begin
                  idx_in   = 2'd0;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = '0;
               rsp_right_in = '0;
               rsp_row_in   = '0;
               rsp_color_in = '0;
               rsp_fin_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ src/mre_checker.sv @@
`include "assert_macros.svh"

module mre_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_BITS+1:0]  rsp_span_left,
   input logic signed [COORD_BITS+1:0]  rsp_span_right,
   input logic signed [COORD_BITS+1:0]  rsp_row,
   input logic [mre_pkg::RGB_BITS-1:0]  rsp_color,
   input logic                          rsp_finished,
   input logic                          rsp_last
);
   import mre_pkg::*;

   logic [3*(COORD_BITS+2)+RGB_BITS+1:0] rsp_payload;
   logic                                 marker_clean;

   assign rsp_payload  = {rsp_span_left, rsp_span_right, rsp_row, rsp_color, rsp_finished,
                          rsp_last};
   assign marker_clean = (rsp_span_left == '0) && (rsp_span_right == '0) && (rsp_row == '0)
                         && (rsp_color == '0) && rsp_last;

   // one request at a time: busy right after taking one
   `MRE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a group still being delivered keeps new requests out
   `MRE_ASSERT_IMPLY(a_group_blocks_req, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // finished marker carries no geometry and closes the request
   `MRE_ASSERT_IMPLY(a_finish_marker, clock, reset, rsp_valid && rsp_finished, marker_clean)

   `MRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind midpoint_ellipse_rasterizer mre_checker #(.COORD_BITS(COORD_BITS)) u_mre_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_span_left  (rsp_bus.span_left),
   .rsp_span_right (rsp_bus.span_right),
   .rsp_row        (rsp_bus.row),
   .rsp_color      (rsp_bus.color),
   .rsp_finished   (rsp_bus.finished),
   .rsp_last       (rsp_bus.last)
);

@@ tb/sv/midpoint_ellipse_rasterizer_tb.sv @@
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;
   import mre_pkg::*;

   localparam int COORD_BITS     = 12;
   localparam int OUT_BITS       = COORD_BITS + 2;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 38;
   localparam int SHOWN_ERRORS   = 10;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] span_left;
      logic signed [OUT_BITS-1:0] span_right;
      logic signed [OUT_BITS-1:0] row;
      logic [RGB_BITS-1:0]        color;
      logic                       finished;
      logic                       last;
   } pixel_type;

   typedef enum logic {
      ROW_REQUEST = 1'b0,
      ROW_CSR     = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         index;
      logic [RGB_BITS-1:0]   data;
      func_type              func;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [COORD_BITS-2:0] rx;
      logic [COORD_BITS-2:0] ry;
      logic [2:0]            hand_count;
      logic [2:0]            hand_first;
   } stimulus_type;

   // results that can be read straight off the geometry
   localparam pixel_type HAND_PIXELS [7] = '{
      '{0, 0, 0, 24'h000000, 1'b1, 1'b1},
      '{4095, 4095, 6142, 24'hFFFFFF, 1'b0, 1'b0},
      '{4095, 4095, 2048, 24'hFFFFFF, 1'b0, 1'b1},
      '{0, 0, 2047, 24'hFFFFFF, 1'b0, 1'b0},
      '{0, 0, -2047, 24'hFFFFFF, 1'b0, 1'b1},
      '{100, 100, 200, 24'hFFFFFF, 1'b0, 1'b0},
      '{100, 100, 200, 24'hFFFFFF, 1'b0, 1'b1}
   };

   localparam stimulus_type DIRECTED [30] = '{
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 1, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 4095, 4095, 2047, 2047, 2, 1},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 0, 0, 2047, 2047, 2, 3},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 100, 200, 0, 0, 2, 5},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 1, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 50, 60, 3, 2, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 30, 40, 0, 5, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 2000, 1000, 7, 1, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, CSR_FILL_ENABLE, 24'h000000, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, CSR_STROKE_RGB, 24'hABCDEF, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 10, 10, 4, 4, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, CSR_STROKE_ENABLE, 24'h000000, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 1, 2, 3, 4, 1, 0},
      '{ROW_CSR, CSR_FILL_ENABLE, 24'h000001, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_CSR, CSR_FILL_RGB, 24'h123456, FUNC_STEP, 0, 0, 0, 0, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_START, 500, 500, 2, 3, 0, 0},
      '{ROW_REQUEST, CSR_FILL_ENABLE, 24'h0, FUNC_STEP, 0, 0, 0, 0, 0, 0}
   };

   localparam bit PHASE_FILL   [PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1};
   localparam bit PHASE_STROKE [PHASES] = '{1, 1, 0, 1, 1, 1, 0, 1};

   logic clock = 1'b0;
   logic reset;

   mre_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   mre_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();
   mre_csr_if csr_bus ();

   midpoint_ellipse_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #1 clock = ~clock;

   // ellipse tracker: configuration and walk state
   logic                fill_on;
   logic                stroke_on;
   logic [RGB_BITS-1:0] fill_rgb_now;
   logic [RGB_BITS-1:0] stroke_rgb_now;
   longint              decision;
   longint              x_term;
   longint              y_term;
   longint              rx_sq;
   longint              ry_sq;
   int                  pos_x;
   int                  pos_y;
   int                  ctr_x;
   int                  ctr_y;
   int                  rad_y;
   region_type          region;
   logic                stroke_pass;

   pixel_type new_pixels[$];
   pixel_type expected_pixels[$];

   int mismatches   = 0;
   int quiet_cycles = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked  = 0;

   function automatic void push_pixel(longint col_lo, longint col_hi, longint row_at,
                                      logic [RGB_BITS-1:0] color, logic fin, logic fin_item);
      pixel_type p;
      p.span_left  = col_lo[OUT_BITS-1:0];
      p.span_right = col_hi[OUT_BITS-1:0];
      p.row        = row_at[OUT_BITS-1:0];
      p.color      = color;
      p.finished   = fin;
      p.last       = fin_item;
      new_pixels.push_back(p);
   endfunction

   function automatic void emit_done_marker();
      push_pixel(0, 0, 0, '0, 1'b1, 1'b1);
   endfunction

   function automatic void emit_group();
      longint cx = ctr_x;
      longint cy = ctr_y;
      longint x  = pos_x;
      longint y  = pos_y;
      if (!stroke_pass) begin
         push_pixel(cx - x, cx + x, cy + y, fill_rgb_now, 1'b0, 1'b0);
         push_pixel(cx - x, cx + x, cy - y, fill_rgb_now, 1'b0, 1'b1);
      end else begin
         push_pixel(cx + x, cx + x, cy + y, stroke_rgb_now, 1'b0, 1'b0);
         push_pixel(cx - x, cx - x, cy + y, stroke_rgb_now, 1'b0, 1'b0);
         push_pixel(cx + x, cx + x, cy - y, stroke_rgb_now, 1'b0, 1'b0);
         push_pixel(cx - x, cx - x, cy - y, stroke_rgb_now, 1'b0, 1'b1);
      end
   endfunction

   function automatic void begin_pass(logic stroke);
      stroke_pass = stroke;
      pos_x       = 0;
      pos_y       = rad_y;
      x_term      = 0;
      y_term      = 2 * rx_sq * rad_y;
      decision    = 4 * ry_sq - 4 * rx_sq * rad_y + rx_sq;
      region      = REGION_ONE;
   endfunction

   // Walks the ellipse by one request; results land in new_pixels.
   function automatic void rasterize(func_type f, logic [COORD_BITS-1:0] cx,
                                     logic [COORD_BITS-1:0] cy, logic [COORD_BITS-2:0] rx,
                                     logic [COORD_BITS-2:0] ry);
      longint tx;
      longint ty;
      new_pixels.delete();
      if (f == FUNC_START) begin
         ctr_x = cx;
         ctr_y = cy;
         rad_y = ry;
         rx_sq = rx;
         rx_sq = rx_sq * rx_sq;
         ry_sq = ry;
         ry_sq = ry_sq * ry_sq;
         if (fill_on) begin
            begin_pass(1'b0);
         end else if (stroke_on) begin
            begin_pass(1'b1);
         end else begin
            region      = REGION_IDLE;
            stroke_pass = 1'b0;
            emit_done_marker();
            return;
         end
         emit_group();
         return;
      end
      if (region == REGION_IDLE) begin
         emit_done_marker();
         return;
      end
      if (region == REGION_ONE) begin
         if (x_term < y_term) begin
            pos_x++;
            x_term += 2 * ry_sq;
            if (decision < 0) begin
               decision += 4 * (ry_sq + x_term);
            end else begin
               pos_y--;
               y_term   -= 2 * rx_sq;
               decision += 4 * (ry_sq + x_term - y_term);
            end
            emit_group();
            return;
         end
         // slope passed -1: restart the decision at the midpoint below
         tx       = 2 * pos_x + 1;
         ty       = pos_y - 1;
         decision = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
         region   = REGION_TWO;
      end
      if (pos_y > 0) begin
         pos_y--;
         y_term -= 2 * rx_sq;
         if (decision > 0) begin
            decision += 4 * (rx_sq - y_term);
         end else begin
            pos_x++;
            x_term   += 2 * ry_sq;
            decision += 4 * (rx_sq - y_term + x_term);
         end
         emit_group();
      end else if (!stroke_pass && stroke_on) begin
         begin_pass(1'b1);
         emit_group();
      end else begin
         region      = REGION_IDLE;
         stroke_pass = 1'b0;
         emit_done_marker();
      end
   endfunction

   task automatic send_request(func_type f, logic [COORD_BITS-1:0] cx,
                               logic [COORD_BITS-1:0] cy, logic [COORD_BITS-2:0] rx,
                               logic [COORD_BITS-2:0] ry, int hand_count = 0,
                               int hand_first = 0);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.func     <= f;
      req_bus.center_x <= cx;
      req_bus.center_y <= cy;
      req_bus.radius_x <= rx;
      req_bus.radius_y <= ry;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      rasterize(f, cx, cy, rx, ry);
      if (hand_count == 0) begin
         foreach (new_pixels[k]) expected_pixels.push_back(new_pixels[k]);
      end else begin
         for (int k = 0; k < hand_count; k++)
            expected_pixels.push_back(HAND_PIXELS[hand_first + k]);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [RGB_BITS-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_FILL_ENABLE:   fill_on        = value[0];
         CSR_STROKE_ENABLE: stroke_on      = value[0];
         CSR_FILL_RGB:      fill_rgb_now   = value;
         CSR_STROKE_RGB:    stroke_rgb_now = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_burst(int budget);
      int sent;
      int pick;
      int rx;
      int ry;
      int steps;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            // mostly small radii so both passes run out to the done marker
            rx    = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
            ry    = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(10);
            steps = 2 * (rx + ry) + 4;
            if ($urandom_range(3) == 0) steps = $urandom_range(steps);
         end else if (pick < 85) begin
            rx    = $urandom_range(2047);
            ry    = $urandom_range(2047);
            steps = $urandom_range(4);
         end else begin
            rx    = -1;
            ry    = 0;
            steps = 1 + $urandom_range(2);
         end
         if (rx >= 0) begin
            if (steps > budget - sent - 1) steps = budget - sent - 1;
            send_request(FUNC_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         (COORD_BITS-1)'(rx), (COORD_BITS-1)'(ry));
            sent++;
         end else if (steps > budget - sent) begin
            steps = budget - sent;
         end
         repeat (steps)
            send_request(FUNC_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         (COORD_BITS-1)'($urandom), (COORD_BITS-1)'($urandom));
         sent += steps;
      end
   endtask

   task automatic note_mismatch(string what, pixel_type want, pixel_type seen);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS) begin
         $display("%s: expected %0d..%0d row %0d color %06h fin %0b last %0b,",
                  what, want.span_left, want.span_right, want.row, want.color,
                  want.finished, want.last);
         $display("   got %0d..%0d row %0d color %06h fin %0b last %0b",
                  seen.span_left, seen.span_right, seen.row, seen.color, seen.finished,
                  seen.last);
      end
   endtask

   // receiver: random stalls plus an occasional long hold-off
   initial begin : receiver
      int holds_begun;
      int hold_left;
      holds_begun   = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_begun != holds_asked) begin
            holds_begun = holds_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      pixel_type seen;
      pixel_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen = '{rsp_bus.span_left, rsp_bus.span_right, rsp_bus.row, rsp_bus.color,
                  rsp_bus.finished, rsp_bus.last};
         if (expected_pixels.size() == 0) begin
            note_mismatch("unexpected result", '0, seen);
         end else begin
            want = expected_pixels.pop_front();
            if (seen !== want) note_mismatch("result mismatch", want, seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [RGB_BITS-1:0] cfg;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.func     = FUNC_START;
      req_bus.center_x = '0;
      req_bus.center_y = '0;
      req_bus.radius_x = '0;
      req_bus.radius_y = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_FILL_ENABLE;
      csr_bus.data     = '0;
      fill_on          = 1'b1;
      stroke_on        = 1'b1;
      fill_rgb_now     = 24'hFFFFFF;
      stroke_rgb_now   = 24'h000000;
      decision         = 0;
      x_term           = 0;
      y_term           = 0;
      rx_sq            = 0;
      ry_sq            = 0;
      pos_x            = 0;
      pos_y            = 0;
      ctr_x            = 0;
      ctr_y            = 0;
      rad_y            = 0;
      region           = REGION_IDLE;
      stroke_pass      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CSR) begin
            wait_for_results();
            write_register(DIRECTED[r].index, DIRECTED[r].data);
         end else begin
            send_request(DIRECTED[r].func, DIRECTED[r].cx, DIRECTED[r].cy, DIRECTED[r].rx,
                         DIRECTED[r].ry, DIRECTED[r].hand_count, DIRECTED[r].hand_first);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // registers change only once every request has fully drained
         wait_for_results();
         cfg    = RGB_BITS'($urandom);
         cfg[0] = PHASE_FILL[phase];
         write_register(CSR_FILL_ENABLE, cfg);
         cfg    = RGB_BITS'($urandom);
         cfg[0] = PHASE_STROKE[phase];
         write_register(CSR_STROKE_ENABLE, cfg);
         write_register(CSR_FILL_RGB, (phase == 0) ? 24'h000000 : 24'($urandom));
         write_register(CSR_STROKE_RGB, (phase == 0) ? 24'hFFFFFF : 24'($urandom));
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin req_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         if (phase == 4) holds_asked++;
         random_burst(PHASE_ITEMS);
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
